// File: sv/assert_macros.svh
// Assertion macros used by the controller (flc_ctrl) of the function lookup cache.
// Depends on nothing; included by modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/flc_pkg.sv
// Package of the function lookup cache: default sizes, commands, states, control structs.
// Depends on nothing.
`default_nettype none
package flc_pkg;
  localparam int CACHE_SLOTS_DEF = 20;
  localparam int MAX_FUNCS_DEF = 64;
  localparam int MAX_OBJECTS_DEF = 16;
  localparam logic [31:0] STAMP_CEILING = 32'h7FFF_FFFF;
  localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_COUNT  = 2'd2,
    CMD_NONE   = 2'd3
  } command_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_PROBE_RD, ST_PROBE, ST_SCAN_RD, ST_SCAN, ST_INSERT, ST_HIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;       // capture request
    logic mod_step;   // one step of hash mod slots
    logic probe_init;
    logic probe_adv;
    logic scan_init;
    logic scan_adv;
    logic do_write;
    logic do_count;
    logic do_insert;
    logic do_hit;
    logic set_miss;
  } ctrl_t;

  typedef struct packed {
    logic mod_done;
    logic slot_empty;
    logic slot_match;
    logic probe_last;
    logic scan_end;
    logic scan_match;
    logic is_lookup;
    logic is_write;
    logic is_count;
  } stat_t;
endpackage
`default_nettype wire

// File: sv/flc_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
`default_nettype none
interface flc_req_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [3:0] object_id;
  logic [5:0] entry_index;
  logic [6:0] entry_count;
  logic [31:0] name_hash;
  modport source (output valid, command, object_id, entry_index, entry_count, name_hash,
                  input ready);
  modport sink (input valid, command, object_id, entry_index, entry_count, name_hash,
                output ready);
endinterface

interface flc_res_if;
  logic valid;
  logic ready;
  logic found;
  logic [5:0] result_index;
  logic cache_hit;
  modport source (output valid, found, result_index, cache_hit, input ready);
  modport sink (input valid, found, result_index, cache_hit, output ready);
endinterface
`default_nettype wire

// File: sv/flc_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module flc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: sv/flc_ctrl.sv
// Controller state machine of the function lookup cache.
// Depends on flc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module flc_ctrl import flc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire stat_t st,
  output ctrl_t ctl
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        priority if (!st.is_lookup) begin
          ctl.do_write = st.is_write;
          ctl.do_count = st.is_count;
          state_next = ST_IDLE;
        end else if (st.mod_done) begin
          ctl.probe_init = 1'b1;
          state_next = ST_PROBE_RD;
        end else begin
          ctl.mod_step = 1'b1;
        end
      end
      ST_PROBE_RD: state_next = ST_PROBE;
      ST_PROBE: begin
        priority if (st.slot_empty) begin
          ctl.scan_init = 1'b1;
          state_next = ST_SCAN_RD;
        end else if (st.slot_match) begin
          ctl.do_hit = 1'b1;
          state_next = ST_OUT;
        end else begin
          ctl.probe_adv = 1'b1;
          if (st.probe_last) begin
            ctl.scan_init = 1'b1;
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (st.scan_end) begin
          ctl.set_miss = 1'b1;
          state_next = ST_OUT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.scan_match) begin
          ctl.do_insert = 1'b1;
          state_next = ST_OUT;
        end else begin
          ctl.scan_adv = 1'b1;
          state_next = ST_SCAN_RD;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_excl, clk, rst, !(in_ready && out_valid))
  `ASSERT_NEXT(a_hit_out, clk, rst, ctl.do_hit || ctl.do_insert, out_valid)
endmodule
`default_nettype wire

// File: sv/flc_dp.sv
// Datapath: cache slot registers, probe and scan counters, name table RAM, result register.
// Depends on flc_pkg and flc_ram.
`default_nettype none
module flc_dp import flc_pkg::*; #(
  parameter int CACHE_SLOTS = CACHE_SLOTS_DEF,
  parameter int MAX_FUNCS = MAX_FUNCS_DEF,
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [1:0] command,
  input  wire logic [3:0] object_id,
  input  wire logic [5:0] entry_index,
  input  wire logic [6:0] entry_count,
  input  wire logic [31:0] name_hash,
  input  wire ctrl_t ctl,
  output stat_t st,
  output logic found,
  output logic [5:0] result_index,
  output logic cache_hit
);
  localparam int SW = $clog2(CACHE_SLOTS);
  localparam int OW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CW = $clog2(MAX_FUNCS + 1);
  localparam int AW = $clog2(MAX_OBJECTS * MAX_FUNCS);
  localparam int DEPTH = MAX_OBJECTS * MAX_FUNCS;
  localparam logic [CW-1:0] MAXF = CW'(MAX_FUNCS);
  // Rounded-up reciprocal of the slot count, exact for every 32-bit hash.
  localparam logic [32:0] RECIP =
    33'((72'(1) << (32 + SW)) / 72'(CACHE_SLOTS) + 72'(1));

  command_t cmd;
  logic [3:0] obj;
  logic [5:0] ent;
  logic [6:0] cnt;
  logic [31:0] hash;
  logic [64:0] prod;
  logic [31:0] quot;
  logic [SW-1:0] rem;
  logic [1:0] mod_ph;
  logic [SW-1:0] idx, victim;
  logic [SW:0] nprobe;
  logic [31:0] best;
  logic [CW-1:0] scan_i, fcount;
  logic slot_valid [CACHE_SLOTS];
  logic [3:0] slot_owner [CACHE_SLOTS];
  logic [31:0] slot_key [CACHE_SLOTS];
  logic [5:0] slot_result [CACHE_SLOTS];
  logic [31:0] slot_stamp [CACHE_SLOTS];
  logic [CW-1:0] function_count [MAX_OBJECTS];
  logic [31:0] use_counter;
  logic [SW-1:0] pidx;
  logic [31:0] cur_key, cur_stamp;
  logic [3:0] cur_owner;
  logic cur_valid;
  logic obj_ok;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_q;
  logic [CW-1:0] cnt_sat;

  assign obj_ok = (32'(obj) < 32'(MAX_OBJECTS));
  assign cnt_sat = (32'(cnt) > 32'(MAX_FUNCS)) ? MAXF : CW'(cnt);

  // Hash mod slots: the reciprocal product is registered first, the remainder the next cycle.
  assign quot = 32'(prod >> (32 + SW));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= command_t'(command);
      obj <= object_id;
      ent <= entry_index;
      cnt <= entry_count;
      hash <= name_hash;
      mod_ph <= '0;
    end
    if (ctl.mod_step) begin
      if (mod_ph == 2'd0) prod <= 65'(hash) * 65'(RECIP);
      else rem <= SW'(hash - quot * 32'(CACHE_SLOTS));
      mod_ph <= mod_ph + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.probe_init) begin
      idx <= rem;
      victim <= rem;
      nprobe <= '0;
      best <= STAMP_CEILING ^ SIGN_BIAS;
    end else if (ctl.probe_adv) begin
      if ((cur_stamp ^ SIGN_BIAS) < best) begin
        best <= cur_stamp ^ SIGN_BIAS;
        victim <= idx;
      end
      idx <= (32'(idx) == CACHE_SLOTS - 1) ? '0 : idx + SW'(1);
      nprobe <= nprobe + (SW+1)'(1);
    end
    if (st.slot_empty && !ctl.probe_adv && ctl.scan_init) victim <= idx;
    if (ctl.scan_init) begin
      scan_i <= '0;
      fcount <= obj_ok ? function_count[OW'(obj)] : '0;
    end else if (ctl.scan_adv) begin
      scan_i <= scan_i + CW'(1);
    end
  end

  assign pidx = idx;
  assign cur_valid = slot_valid[pidx];
  assign cur_owner = slot_owner[pidx];
  assign cur_key = slot_key[pidx];
  assign cur_stamp = slot_stamp[pidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_owner[i] <= '0;
        slot_key[i] <= '0;
        slot_result[i] <= '0;
        slot_stamp[i] <= '0;
      end
      for (int j = 0; j < MAX_OBJECTS; j++) function_count[j] <= '0;
      use_counter <= '0;
    end else begin
      if (ctl.do_count && obj_ok) function_count[OW'(obj)] <= cnt_sat;
      if (ctl.do_hit) begin
        slot_stamp[pidx] <= use_counter;
        use_counter <= use_counter + 32'd1;
      end
      if (ctl.do_insert) begin
        slot_valid[victim] <= 1'b1;
        slot_owner[victim] <= obj;
        slot_key[victim] <= hash;
        slot_result[victim] <= 6'(scan_i);
        slot_stamp[victim] <= use_counter;
        use_counter <= use_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_hit) begin
      found <= 1'b1;
      result_index <= slot_result[pidx];
      cache_hit <= 1'b1;
    end else if (ctl.do_insert) begin
      found <= 1'b1;
      result_index <= 6'(scan_i);
      cache_hit <= 1'b0;
    end else if (ctl.set_miss) begin
      found <= 1'b0;
      result_index <= '0;
      cache_hit <= 1'b0;
    end
  end

  assign ram_we = ctl.do_write && obj_ok && (32'(ent) < 32'(MAX_FUNCS));
  always_comb begin
    if (ctl.do_write) ram_addr = AW'(32'(obj) * MAX_FUNCS + 32'(ent));
    else ram_addr = AW'(32'(obj) * MAX_FUNCS + 32'(scan_i));
  end

  flc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(hash), .rdata(ram_q)
  );

  assign st.mod_done = (mod_ph == 2'd2);
  assign st.slot_empty = !cur_valid;
  assign st.slot_match = cur_valid && (cur_owner == obj) && (cur_key == hash);
  assign st.probe_last = (32'(nprobe) == CACHE_SLOTS - 1);
  assign st.scan_end = (scan_i >= fcount);
  assign st.scan_match = (ram_q == hash);
  assign st.is_lookup = (cmd == CMD_LOOKUP);
  assign st.is_write = (cmd == CMD_WRITE);
  assign st.is_count = (cmd == CMD_COUNT);
endmodule
`default_nettype wire

// File: sv/function_lookup_lru_cache.sv
// Top level of the function lookup cache: controller plus datapath.
// Depends on flc_pkg, flc_if, flc_ctrl and flc_dp.
// One request at a time. A load is accepted and then decoded, which writes the name table
// entry or the function count. A lookup is accepted, reduces the hash modulo CACHE_SLOTS
// by reciprocal multiplication, starts the probe, probes cache slots (up to CACHE_SLOTS)
// and, on a cache miss, scans name table entries through the single RAM port, a read and
// a compare per entry (up to the object's function count), ends the scan when no entry
// matches, and presents the result until it is taken.
`default_nettype none
module function_lookup_lru_cache import flc_pkg::*; #(
  parameter int CACHE_SLOTS = CACHE_SLOTS_DEF,
  parameter int MAX_FUNCS = MAX_FUNCS_DEF,
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  flc_req_if.sink req,
  flc_res_if.source res
);
  ctrl_t ctl;
  stat_t st;

  flc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(res.valid), .out_ready(res.ready), .st(st), .ctl(ctl)
  );

  flc_dp #(.CACHE_SLOTS(CACHE_SLOTS), .MAX_FUNCS(MAX_FUNCS), .MAX_OBJECTS(MAX_OBJECTS)) u_dp (
    .clk(clk), .rst(rst), .command(req.command), .object_id(req.object_id),
    .entry_index(req.entry_index), .entry_count(req.entry_count),
    .name_hash(req.name_hash), .ctl(ctl), .st(st), .found(res.found),
    .result_index(res.result_index), .cache_hit(res.cache_hit)
  );
endmodule
`default_nettype wire

// File: tb/tb_function_lookup_lru_cache.sv
// Self-checking testbench for the function lookup cache with LRU replacement.
// Depends on flc_pkg, the request/result interfaces and function_lookup_lru_cache.
// Drives loads and lookups, predicts every answer and compares it with the result channel.
`timescale 1ns / 100ps
module tb_function_lookup_lru_cache;
  import flc_pkg::*;

  localparam int SLOTS = CACHE_SLOTS_DEF;
  localparam int FUNCS = MAX_FUNCS_DEF;
  localparam int OBJS = MAX_OBJECTS_DEF;
  localparam int POOL = 40;
  localparam int TOTAL_REQUESTS = 2000;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    command_t cmd;
    logic [3:0] obj;
    logic [5:0] ent;
    logic [6:0] cnt;
    logic [31:0] hash;
  } request_t;

  typedef struct packed {
    logic found;
    logic [5:0] index;
    logic hit;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  flc_req_if req_ch();
  flc_res_if res_ch();

  function_lookup_lru_cache u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // Mirror of the block's state.
  logic slot_used [SLOTS];
  logic [3:0] slot_obj [SLOTS];
  logic [31:0] slot_hash [SLOTS];
  logic [5:0] slot_func [SLOTS];
  logic [31:0] slot_age [SLOTS];
  logic [31:0] age_counter;
  logic [31:0] names [OBJS][FUNCS];
  logic [6:0] func_total [OBJS];

  // Generator bookkeeping: which name entries have been written so far.
  logic name_written [OBJS][FUNCS];
  logic [31:0] hash_pool [POOL];

  request_t pending_requests[$];
  answer_t expected_answers[$];

  int unsigned lookups_sent = 0;
  int unsigned hits_seen = 0;
  int unsigned answers_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic answer_t resolve_lookup(logic [3:0] obj, logic [31:0] hash);
    answer_t a;
    int pos;
    int victim;
    logic [31:0] best;
    int total;
    pos = hash % SLOTS;
    victim = pos;
    best = STAMP_CEILING ^ SIGN_BIAS;
    a = '0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used[pos]) begin
        victim = pos;
        break;
      end
      if (slot_obj[pos] == obj && slot_hash[pos] == hash) begin
        slot_age[pos] = age_counter;
        age_counter = age_counter + 1;
        a.found = 1'b1;
        a.index = slot_func[pos];
        a.hit = 1'b1;
        return a;
      end
      if ((slot_age[pos] ^ SIGN_BIAS) < best) begin
        best = slot_age[pos] ^ SIGN_BIAS;
        victim = pos;
      end
      pos = (pos + 1 >= SLOTS) ? 0 : pos + 1;
    end
    total = func_total[obj];
    for (int i = 0; i < total; i++) begin
      if (names[obj][i] == hash) begin
        slot_used[victim] = 1'b1;
        slot_obj[victim] = obj;
        slot_hash[victim] = hash;
        slot_func[victim] = i[5:0];
        slot_age[victim] = age_counter;
        age_counter = age_counter + 1;
        a.found = 1'b1;
        a.index = i[5:0];
        return a;
      end
    end
    return a;
  endfunction

  task automatic apply_request(request_t r);
    answer_t a;
    case (r.cmd)
      CMD_LOOKUP: begin
        a = resolve_lookup(r.obj, r.hash);
        expected_answers = {expected_answers, a};
        lookups_sent++;
      end
      CMD_WRITE: names[r.obj][r.ent] = r.hash;
      CMD_COUNT: func_total[r.obj] = (r.cnt > FUNCS) ? FUNCS[6:0] : r.cnt;
      default: ;
    endcase
  endtask

  task automatic queue_request(command_t cmd, logic [3:0] obj, logic [5:0] ent,
                               logic [6:0] cnt, logic [31:0] hash);
    request_t r;
    r.cmd = cmd;
    r.obj = obj;
    r.ent = ent;
    r.cnt = cnt;
    r.hash = hash;
    if (cmd == CMD_WRITE) name_written[obj][ent] = 1'b1;
    pending_requests = {pending_requests, r};
  endtask

  // A count may only cover entries that hold a name, so fill the gaps first.
  task automatic queue_count(logic [3:0] obj, logic [6:0] cnt);
    int lim;
    lim = (cnt > FUNCS) ? FUNCS : cnt;
    for (int i = 0; i < lim; i++)
      if (!name_written[obj][i])
        queue_request(CMD_WRITE, obj, i[5:0], 7'($urandom),
                      hash_pool[$urandom_range(0, POOL - 1)]);
    queue_request(CMD_COUNT, obj, 6'($urandom), cnt, $urandom);
  endtask

  function automatic logic [31:0] pick_hash();
    return ($urandom_range(0, 9) == 0) ? $urandom : hash_pool[$urandom_range(0, POOL - 1)];
  endfunction

  // Request driver.
  int req_gap = 0;
  logic req_no_gaps = 1'b0;
  request_t current_request;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) apply_request(current_request);
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          current_request = pending_requests.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.command <= current_request.cmd;
          req_ch.object_id <= current_request.obj;
          req_ch.entry_index <= current_request.ent;
          req_ch.entry_count <= current_request.cnt;
          req_ch.name_hash <= current_request.hash;
          if ($urandom_range(0, 99) == 0) req_no_gaps <= ~req_no_gaps;
          req_gap <= req_no_gaps ? 0 : $urandom_range(0, 3);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready generator.
  int res_stall = 0;
  logic res_no_stalls = 1'b0;

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result found=%0b index=%0d hit=%0b",
                     res_ch.found, res_ch.result_index, res_ch.cache_hit);
        end else begin
          want = expected_answers.pop_front();
          answers_checked++;
          if (res_ch.cache_hit) hits_seen++;
          if (res_ch.found !== want.found || res_ch.result_index !== want.index ||
              res_ch.cache_hit !== want.hit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d expected found=%0b index=%0d hit=%0b, got %0b %0d %0b",
                       answers_checked, want.found, want.index, want.hit,
                       res_ch.found, res_ch.result_index, res_ch.cache_hit);
          end
        end
        if ($urandom_range(0, 49) == 0) res_no_stalls <= ~res_no_stalls;
        res_stall <= res_no_stalls ? 0 : $urandom_range(0, 3);
        res_ch.ready <= res_no_stalls;
      end else if (res_stall > 0) begin
        res_stall <= res_stall - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_function_lookup_lru_cache NOT OK");
      $finish;
    end
  end

  initial begin
    int pick;
    logic [3:0] obj;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_NONE;
    req_ch.object_id = '0;
    req_ch.entry_index = '0;
    req_ch.entry_count = '0;
    req_ch.name_hash = '0;
    res_ch.ready = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s] = 1'b0;
      slot_obj[s] = '0;
      slot_hash[s] = '0;
      slot_func[s] = '0;
      slot_age[s] = '0;
    end
    age_counter = '0;
    for (int o = 0; o < OBJS; o++) begin
      func_total[o] = '0;
      for (int f = 0; f < FUNCS; f++) begin
        names[o][f] = '0;
        name_written[o][f] = 1'b0;
      end
    end
    hash_pool[0] = 32'h0000_0000;
    hash_pool[1] = 32'hFFFF_FFFF;
    for (int p = 2; p < POOL; p++) hash_pool[p] = $urandom;

    // Directed part: empty object, extreme hashes and indexes, hit after miss,
    // saturated count, zero count, the unused command and stale entries.
    queue_request(CMD_LOOKUP, 4'd15, 6'd0, 7'd0, 32'hFFFF_FFFF);
    queue_request(CMD_WRITE, 4'd0, 6'd0, 7'd127, 32'h0000_0000);
    queue_request(CMD_WRITE, 4'd0, 6'd1, 7'd0, 32'hFFFF_FFFF);
    queue_request(CMD_WRITE, 4'd0, 6'd2, 7'd0, hash_pool[2]);
    queue_count(4'd0, 7'd3);
    queue_request(CMD_LOOKUP, 4'd0, 6'd63, 7'd127, 32'hFFFF_FFFF);
    queue_request(CMD_LOOKUP, 4'd0, 6'd0, 7'd0, 32'hFFFF_FFFF);
    queue_request(CMD_LOOKUP, 4'd0, 6'd0, 7'd0, 32'h0000_0000);
    queue_request(CMD_LOOKUP, 4'd1, 6'd0, 7'd0, 32'h0000_0000);
    queue_request(CMD_WRITE, 4'd0, 6'd1, 7'd0, hash_pool[3]);
    queue_request(CMD_LOOKUP, 4'd0, 6'd0, 7'd0, 32'hFFFF_FFFF);
    queue_request(CMD_NONE, 4'd15, 6'd63, 7'd127, 32'hFFFF_FFFF);
    queue_request(CMD_WRITE, 4'd15, 6'd63, 7'd0, hash_pool[4]);
    queue_count(4'd15, 7'd127);
    queue_request(CMD_LOOKUP, 4'd15, 6'd0, 7'd0, hash_pool[4]);
    queue_request(CMD_LOOKUP, 4'd15, 6'd0, 7'd0, hash_pool[4]);
    queue_count(4'd15, 7'd0);
    queue_request(CMD_LOOKUP, 4'd15, 6'd0, 7'd0, hash_pool[5]);

    // Random part: mostly lookups on pooled hashes so hits and evictions are common.
    while (pending_requests.size() < TOTAL_REQUESTS) begin
      pick = $urandom_range(0, 99);
      obj = $urandom_range(0, OBJS - 1);
      if (pick < 62)
        queue_request(CMD_LOOKUP, obj, 6'($urandom), 7'($urandom), pick_hash());
      else if (pick < 80)
        queue_request(CMD_WRITE, obj, 6'($urandom), 7'($urandom), pick_hash());
      else if (pick < 92)
        queue_count(obj, ($urandom_range(0, 7) == 0) ? 7'($urandom) :
                         7'($urandom_range(0, 12)));
      else if (pick < 96)
        queue_request(CMD_NONE, obj, 6'($urandom), 7'($urandom), $urandom);
      else
        queue_request(CMD_LOOKUP, obj, 6'($urandom), 7'($urandom), $urandom);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (pending_requests.size() == 0 && !req_ch.valid);
    wait (expected_answers.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d lookups plus loads; checked %0d results, %0d of them cache hits.",
             lookups_sent, answers_checked, hits_seen);
    $display("Mismatches: %0d, answers still outstanding: %0d.",
             mismatches, expected_answers.size());
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("tb_function_lookup_lru_cache OK");
    end else begin
      $display("tb_function_lookup_lru_cache NOT OK");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/flc_pkg.sv
sv/flc_if.sv
sv/flc_ram.sv
sv/flc_ctrl.sv
sv/flc_dp.sv
sv/function_lookup_lru_cache.sv
tb/tb_function_lookup_lru_cache.sv
